// ----- design/ole_pkg.sv -----
// Shared types and constants for the ordered list engine.
// Holds the request/result structs, opcodes, controller states and micro-ops.
// No dependencies.
package ole_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 5;
    localparam int WIDE_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OP_W-1:0] OP_GET     = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd3;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } in_item_t;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [POS_W-1:0]        found_position;
        logic [LEN_W-1:0]        length;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOVE,
        ST_DRAIN,
        ST_PUT,
        ST_GET,
        ST_FIND,
        ST_REV_RD_HI,
        ST_REV_WR_LO,
        ST_REV_WR_HI,
        ST_RESULT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MOVE,
        DP_INS_PUT,
        DP_DEL_DONE,
        DP_GET_RD,
        DP_GET_CAP,
        DP_FIND,
        DP_FIND_HIT,
        DP_FIND_MISS,
        DP_REV_RD_LO,
        DP_REV_RD_HI,
        DP_REV_WR_LO,
        DP_REV_WR_HI,
        DP_SET_OK
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   publish;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            ins_legal;
        logic            pos_legal;
        logic            ins_nomove;
        logic            del_nomove;
        logic            rev_legal;
        logic            move_last;
        logic            rev_more;
        logic            find_hit;
        logic            find_more;
    } dp_stat_t;

endpackage

// ----- design/ole_dpath.sv -----
// Datapath of the ordered list engine: entry memory, count, pointers, result register.
// Executes one micro-op per cycle from ole_ctrl and reports status back.
// Depends on ole_pkg.
module ole_dpath (
    input  logic               aclk,
    input  logic               aresetn,
    input  ole_pkg::in_item_t  s_item,
    input  ole_pkg::dp_cmd_t   cmd,
    output ole_pkg::dp_stat_t  stat,
    output ole_pkg::out_item_t m_item
);

    logic [ole_pkg::VAL_W-1:0]  mem_array [ole_pkg::CAPACITY];

    logic [ole_pkg::OP_W-1:0]   op_reg;
    logic [ole_pkg::POS_W-1:0]  pos_reg;
    logic [ole_pkg::VAL_W-1:0]  val_reg;
    logic [ole_pkg::CNT_W-1:0]  count_reg;
    logic [ole_pkg::CNT_W-1:0]  count_next;
    logic [ole_pkg::CNT_W-1:0]  a_reg;
    logic [ole_pkg::CNT_W-1:0]  b_reg;
    logic [ole_pkg::CNT_W-1:0]  cmp_idx_reg;
    logic [ole_pkg::VAL_W-1:0]  temp_reg;
    logic [ole_pkg::VAL_W-1:0]  rdata_reg;
    logic [ole_pkg::ADDR_W-1:0] dst_pipe_reg;
    logic                       mv_pend_reg;
    logic                       cmp_pend_reg;
    logic                       res_ok_reg;
    logic [ole_pkg::VAL_W-1:0]  res_rd_reg;
    logic [ole_pkg::POS_W-1:0]  res_fpos_reg;
    ole_pkg::out_item_t         out_reg;

    logic [ole_pkg::WIDE_W-1:0] pos_w;
    logic [ole_pkg::WIDE_W-1:0] cnt_w;
    logic [ole_pkg::WIDE_W-1:0] pos_m1;
    logic [ole_pkg::WIDE_W-1:0] hit_w;
    logic [ole_pkg::WIDE_W-1:0] miss_w;
    logic [ole_pkg::CNT_W-1:0]  a_inc;
    logic [ole_pkg::CNT_W-1:0]  in_pos;
    logic [ole_pkg::CNT_W-1:0]  load_a;
    logic [ole_pkg::CNT_W-1:0]  load_b;

    logic                       rd_en;
    logic [ole_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;
    logic [ole_pkg::ADDR_W-1:0] wr_addr;
    logic [ole_pkg::VAL_W-1:0]  wr_data;

    assign pos_w  = ole_pkg::WIDE_W'(pos_reg);
    assign cnt_w  = ole_pkg::WIDE_W'(count_reg);
    assign pos_m1 = pos_w - ole_pkg::WIDE_W'(1);
    assign hit_w  = ole_pkg::WIDE_W'(cmp_idx_reg) + ole_pkg::WIDE_W'(1);
    assign miss_w = cnt_w + ole_pkg::WIDE_W'(1);
    assign a_inc  = a_reg + ole_pkg::CNT_W'(1);
    assign in_pos = ole_pkg::CNT_W'(s_item.position);

    always_comb begin
        stat.opcode     = op_reg;
        stat.ins_legal  = (cnt_w < ole_pkg::WIDE_W'(ole_pkg::CAPACITY)) &&
                          (pos_w != '0) && (pos_w <= miss_w);
        stat.pos_legal  = (pos_w != '0) && (pos_w <= cnt_w);
        stat.ins_nomove = (pos_w == miss_w);
        stat.del_nomove = (pos_w == cnt_w);
        stat.rev_legal  = (cnt_w >= ole_pkg::WIDE_W'(2));
        stat.move_last  = (op_reg == ole_pkg::OP_INSERT) ?
                          (b_reg == ole_pkg::CNT_W'(pos_reg)) :
                          (a_reg == count_reg - ole_pkg::CNT_W'(1));
        stat.rev_more   = (ole_pkg::WIDE_W'(a_reg) + ole_pkg::WIDE_W'(2)) <
                          ole_pkg::WIDE_W'(b_reg);
        stat.find_hit   = cmp_pend_reg && (rdata_reg == val_reg);
        stat.find_more  = (a_reg < count_reg);
    end

    // pointer setup: a = source / low end, b = destination / high end
    always_comb begin
        load_a = '0;
        load_b = '0;
        unique case (s_item.opcode)
            ole_pkg::OP_INSERT: begin
                load_a = count_reg - ole_pkg::CNT_W'(1);
                load_b = count_reg;
            end
            ole_pkg::OP_DELETE: begin
                load_a = in_pos;
                load_b = in_pos - ole_pkg::CNT_W'(1);
            end
            ole_pkg::OP_GET: begin
                load_a = in_pos - ole_pkg::CNT_W'(1);
            end
            ole_pkg::OP_REVERSE: begin
                load_b = count_reg - ole_pkg::CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = a_reg[ole_pkg::ADDR_W-1:0];
        wr_en   = mv_pend_reg;
        wr_addr = dst_pipe_reg;
        wr_data = rdata_reg;
        unique case (cmd.op) inside
            ole_pkg::DP_MOVE, ole_pkg::DP_FIND, ole_pkg::DP_GET_RD,
            ole_pkg::DP_REV_RD_LO: begin
                rd_en = 1'b1;
            end
            ole_pkg::DP_REV_RD_HI: begin
                rd_en   = 1'b1;
                rd_addr = b_reg[ole_pkg::ADDR_W-1:0];
            end
            ole_pkg::DP_REV_WR_LO: begin
                wr_en   = 1'b1;
                wr_addr = a_reg[ole_pkg::ADDR_W-1:0];
            end
            ole_pkg::DP_REV_WR_HI: begin
                rd_en   = 1'b1;
                rd_addr = a_inc[ole_pkg::ADDR_W-1:0];
                wr_en   = 1'b1;
                wr_addr = b_reg[ole_pkg::ADDR_W-1:0];
                wr_data = temp_reg;
            end
            ole_pkg::DP_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = pos_m1[ole_pkg::ADDR_W-1:0];
                wr_data = val_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem_array[rd_addr];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.op == ole_pkg::DP_INS_PUT) begin
            count_next = count_reg + ole_pkg::CNT_W'(1);
        end else if (cmd.op == ole_pkg::DP_DEL_DONE) begin
            count_next = count_reg - ole_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            mv_pend_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            mv_pend_reg  <= (cmd.op == ole_pkg::DP_MOVE);
            cmp_pend_reg <= (cmd.op == ole_pkg::DP_FIND);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op) inside
            ole_pkg::DP_LOAD: begin
                op_reg       <= s_item.opcode;
                pos_reg      <= s_item.position;
                val_reg      <= s_item.item_value;
                a_reg        <= load_a;
                b_reg        <= load_b;
                res_ok_reg   <= 1'b0;
                res_rd_reg   <= '0;
                res_fpos_reg <= '0;
            end
            ole_pkg::DP_MOVE: begin
                dst_pipe_reg <= b_reg[ole_pkg::ADDR_W-1:0];
                if (op_reg == ole_pkg::OP_INSERT) begin
                    a_reg <= a_reg - ole_pkg::CNT_W'(1);
                    b_reg <= b_reg - ole_pkg::CNT_W'(1);
                end else begin
                    a_reg <= a_inc;
                    b_reg <= b_reg + ole_pkg::CNT_W'(1);
                end
            end
            ole_pkg::DP_INS_PUT, ole_pkg::DP_DEL_DONE, ole_pkg::DP_SET_OK: begin
                res_ok_reg <= 1'b1;
            end
            ole_pkg::DP_GET_CAP: begin
                res_ok_reg <= 1'b1;
                res_rd_reg <= rdata_reg;
            end
            ole_pkg::DP_FIND: begin
                cmp_idx_reg <= a_reg;
                a_reg       <= a_inc;
            end
            ole_pkg::DP_FIND_HIT: begin
                res_ok_reg   <= 1'b1;
                res_fpos_reg <= hit_w[ole_pkg::POS_W-1:0];
            end
            ole_pkg::DP_FIND_MISS: begin
                res_fpos_reg <= miss_w[ole_pkg::POS_W-1:0];
            end
            ole_pkg::DP_REV_RD_HI: begin
                temp_reg <= rdata_reg;
            end
            ole_pkg::DP_REV_WR_HI: begin
                res_ok_reg <= 1'b1;
                a_reg      <= a_inc;
                b_reg      <= b_reg - ole_pkg::CNT_W'(1);
            end
            default: begin
            end
        endcase
        if (cmd.publish) begin
            out_reg.ok             <= res_ok_reg;
            out_reg.read_value     <= $signed(res_rd_reg);
            out_reg.found_position <= res_fpos_reg;
            out_reg.length         <= cnt_w[ole_pkg::LEN_W-1:0];
        end
    end

    assign m_item = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ole_pkg::CNT_W'(ole_pkg::CAPACITY))
        else $error("entry count above capacity");
    a_put_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ole_pkg::DP_INS_PUT) |-> (count_reg < ole_pkg::CNT_W'(ole_pkg::CAPACITY)))
        else $error("insert write into full list");
    a_wport_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_pend_reg |-> (cmd.op == ole_pkg::DP_MOVE || cmd.op == ole_pkg::DP_NOP ||
                         cmd.op == ole_pkg::DP_DEL_DONE))
        else $error("write port clash with pending move");
`endif

endmodule

// ----- design/ole_ctrl.sv -----
// Controller of the ordered list engine: sequences micro-ops per request.
// Owns the request/result handshakes; talks to ole_dpath through dp_cmd_t/dp_stat_t.
// Depends on ole_pkg.
module ole_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ole_pkg::dp_stat_t stat,
    output ole_pkg::dp_cmd_t  cmd
);

    ole_pkg::ctrl_state_t state_reg;
    ole_pkg::ctrl_state_t state_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ole_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ole_pkg::ST_DECODE;
                end
            end
            ole_pkg::ST_DECODE: begin
                state_next = ole_pkg::ST_RESULT;
                unique case (stat.opcode)
                    ole_pkg::OP_INSERT: begin
                        if (stat.ins_legal && !stat.ins_nomove) begin
                            state_next = ole_pkg::ST_MOVE;
                        end
                    end
                    ole_pkg::OP_DELETE: begin
                        if (stat.pos_legal && !stat.del_nomove) begin
                            state_next = ole_pkg::ST_MOVE;
                        end
                    end
                    ole_pkg::OP_GET: begin
                        if (stat.pos_legal) begin
                            state_next = ole_pkg::ST_GET;
                        end
                    end
                    ole_pkg::OP_FIND: begin
                        state_next = ole_pkg::ST_FIND;
                    end
                    ole_pkg::OP_REVERSE: begin
                        if (stat.rev_legal) begin
                            state_next = ole_pkg::ST_REV_RD_HI;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ole_pkg::ST_MOVE: begin
                if (stat.move_last) begin
                    state_next = ole_pkg::ST_DRAIN;
                end
            end
            ole_pkg::ST_DRAIN: begin
                state_next = (stat.opcode == ole_pkg::OP_INSERT) ?
                             ole_pkg::ST_PUT : ole_pkg::ST_RESULT;
            end
            ole_pkg::ST_PUT: begin
                state_next = ole_pkg::ST_RESULT;
            end
            ole_pkg::ST_GET: begin
                state_next = ole_pkg::ST_RESULT;
            end
            ole_pkg::ST_FIND: begin
                if (stat.find_hit || !stat.find_more) begin
                    state_next = ole_pkg::ST_RESULT;
                end
            end
            ole_pkg::ST_REV_RD_HI: begin
                state_next = ole_pkg::ST_REV_WR_LO;
            end
            ole_pkg::ST_REV_WR_LO: begin
                state_next = ole_pkg::ST_REV_WR_HI;
            end
            ole_pkg::ST_REV_WR_HI: begin
                state_next = stat.rev_more ? ole_pkg::ST_REV_RD_HI : ole_pkg::ST_RESULT;
            end
            ole_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = ole_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ole_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.op      = ole_pkg::DP_NOP;
        cmd.publish = 1'b0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ole_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = ole_pkg::DP_LOAD;
                end
            end
            ole_pkg::ST_DECODE: begin
                unique case (stat.opcode)
                    ole_pkg::OP_INSERT: begin
                        if (stat.ins_legal && stat.ins_nomove) begin
                            cmd.op = ole_pkg::DP_INS_PUT;
                        end
                    end
                    ole_pkg::OP_DELETE: begin
                        if (stat.pos_legal && stat.del_nomove) begin
                            cmd.op = ole_pkg::DP_DEL_DONE;
                        end
                    end
                    ole_pkg::OP_GET: begin
                        if (stat.pos_legal) begin
                            cmd.op = ole_pkg::DP_GET_RD;
                        end
                    end
                    ole_pkg::OP_REVERSE: begin
                        cmd.op = stat.rev_legal ? ole_pkg::DP_REV_RD_LO : ole_pkg::DP_SET_OK;
                    end
                    default: begin
                    end
                endcase
            end
            ole_pkg::ST_MOVE: begin
                cmd.op = ole_pkg::DP_MOVE;
            end
            ole_pkg::ST_DRAIN: begin
                if (stat.opcode == ole_pkg::OP_DELETE) begin
                    cmd.op = ole_pkg::DP_DEL_DONE;
                end
            end
            ole_pkg::ST_PUT: begin
                cmd.op = ole_pkg::DP_INS_PUT;
            end
            ole_pkg::ST_GET: begin
                cmd.op = ole_pkg::DP_GET_CAP;
            end
            ole_pkg::ST_FIND: begin
                if (stat.find_hit) begin
                    cmd.op = ole_pkg::DP_FIND_HIT;
                end else if (stat.find_more) begin
                    cmd.op = ole_pkg::DP_FIND;
                end else begin
                    cmd.op = ole_pkg::DP_FIND_MISS;
                end
            end
            ole_pkg::ST_REV_RD_HI: begin
                cmd.op = ole_pkg::DP_REV_RD_HI;
            end
            ole_pkg::ST_REV_WR_LO: begin
                cmd.op = ole_pkg::DP_REV_WR_LO;
            end
            ole_pkg::ST_REV_WR_HI: begin
                cmd.op = ole_pkg::DP_REV_WR_HI;
            end
            ole_pkg::ST_RESULT: begin
                cmd.publish = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ole_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_valid_reg || m_ready))
        else $error("result overwrites unaccepted result");
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while busy");
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ole_pkg::ST_RESULT))
        else $error("result raised outside result state");
`endif

endmodule

// ----- design/ordered_list_engine_core.sv -----
// Top level of the ordered list engine: bounded ordered list of signed 32-bit values.
// Instantiates ole_ctrl (sequencer) and ole_dpath (entry memory and result register).
// Depends on ole_pkg.
//
//  channel   ports                         payload      direction
//  request   s_valid s_ready s_item        in_item_t    in
//  result    m_valid m_ready m_item        out_item_t   out
//
// One request at a time; the result register lets the next request in while a
// result waits. Insert and delete shift the entries behind the position one at
// a time, find scans from the first entry until a hit, reverse swaps pairs from
// both ends, and failed or unused commands go straight to the result (one memory
// access per port per cycle). Synchronous active-low reset empties the list;
// a stalled result holds the engine in its result state after the next request.
module ordered_list_engine_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ole_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ole_pkg::out_item_t m_item
);

    ole_pkg::dp_cmd_t  cmd;
    ole_pkg::dp_stat_t stat;

    ole_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ole_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .stat    (stat),
        .m_item  (m_item)
    );

endmodule

// ----- dv/ole_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the ordered list engine: watches the request and result channels,
// predicts every result from its own copy of the list and compares field by field.
// Depends on ole_pkg.
module ole_checker
    import ole_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_item_t         s_item,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_item_t        m_item,
    output logic [LEN_W-1:0] list_len,
    output int               pending,
    output int               error_count
);

    logic [VAL_W-1:0] entries [CAPACITY];
    int               entry_total;
    out_item_t        expected_results [$];
    int               result_idx;

    initial begin
        error_count = 0;
        pending     = 0;
        list_len    = '0;
        entry_total = 0;
        result_idx  = 0;
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one command to the shadow list and returns the result it must produce.
    function automatic out_item_t apply_command(in_item_t req);
        out_item_t        res;
        int               pos;
        int               lo;
        int               hi;
        logic [VAL_W-1:0] swap;
        res = '0;
        pos = int'(req.position);
        case (req.opcode)
            OP_INSERT: begin
                if (entry_total < CAPACITY && pos >= 1 && pos <= entry_total + 1) begin
                    for (int i = entry_total; i >= pos; i--)
                        entries[i] = entries[i - 1];
                    entries[pos - 1] = req.item_value;
                    entry_total++;
                    res.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (pos >= 1 && pos <= entry_total) begin
                    for (int i = pos; i < entry_total; i++)
                        entries[i - 1] = entries[i];
                    entry_total--;
                    res.ok = 1'b1;
                end
            end
            OP_GET: begin
                if (pos >= 1 && pos <= entry_total) begin
                    res.read_value = entries[pos - 1];
                    res.ok         = 1'b1;
                end
            end
            OP_FIND: begin
                res.found_position = POS_W'(entry_total + 1);
                for (int i = 0; i < entry_total; i++) begin
                    if (entries[i] == req.item_value) begin
                        res.found_position = POS_W'(i + 1);
                        res.ok             = 1'b1;
                        break;
                    end
                end
            end
            OP_REVERSE: begin
                lo = 0;
                hi = entry_total - 1;
                while (lo < hi) begin
                    swap        = entries[lo];
                    entries[lo] = entries[hi];
                    entries[hi] = swap;
                    lo++;
                    hi--;
                end
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.length = LEN_W'(entry_total);
        return res;
    endfunction

    always @(posedge aclk) begin : track
        out_item_t want;
        if (!aresetn) begin
            entry_total = 0;
            result_idx  = 0;
            expected_results.delete();
        end else begin
            // results first: a result never belongs to a request taken at the same edge
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none outstanding",
                                              result_idx));
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.ok !== want.ok)
                        report_mismatch($sformatf("result %0d ok: got %b, expected %b",
                                                  result_idx, m_item.ok, want.ok));
                    if (m_item.read_value !== want.read_value)
                        report_mismatch($sformatf("result %0d read_value: got %h, expected %h",
                                                  result_idx, m_item.read_value,
                                                  want.read_value));
                    if (m_item.found_position !== want.found_position)
                        report_mismatch($sformatf("result %0d found_position: got %0d, expected %0d",
                                                  result_idx, m_item.found_position,
                                                  want.found_position));
                    if (m_item.length !== want.length)
                        report_mismatch($sformatf("result %0d length: got %0d, expected %0d",
                                                  result_idx, m_item.length, want.length));
                end
                result_idx++;
            end
            if (s_valid && s_ready)
                expected_results.push_back(apply_command(s_item));
        end
        list_len = LEN_W'(entry_total);
        pending  = expected_results.size();
    end

endmodule

// ----- dv/tb_ordered_list_engine_core.sv -----
`timescale 1ns / 100ps
// Top of the ordered list engine testbench: clock, reset, request and result drivers.
// Checking is done by ole_checker; depends on ole_pkg and ordered_list_engine_core.
module tb_ordered_list_engine_core;
    import ole_pkg::*;

    localparam int RANDOM_REQUESTS = 625;
    localparam int MODE_SPAN       = 50;
    localparam int HOLD_AT         = 240;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int POOL_DEPTH      = 24;
    localparam int POS_MAX         = (1 << POS_W) - 1;
    localparam logic [OP_W-1:0] OP_TOP_CODE = '1;

    typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_t;

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_item_t         s_item  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_item_t        m_item;
    logic [LEN_W-1:0] list_len;
    int               pending;
    int               error_count;

    logic signed [VAL_W-1:0] value_pool [$];
    logic signed [VAL_W-1:0] corner_values [4] = '{32'sh0, -32'sd1, 32'sh7FFF_FFFF,
                                                   32'sh8000_0000};

    always #5 aclk = ~aclk;

    ordered_list_engine_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    ole_checker i_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .list_len    (list_len),
        .pending     (pending),
        .error_count (error_count)
    );

    function automatic in_item_t mk(logic [OP_W-1:0] op, int pos, logic [VAL_W-1:0] val);
        in_item_t req;
        req.opcode     = op;
        req.position   = POS_W'(pos);
        req.item_value = val;
        return req;
    endfunction

    // Mostly legal positions against the current length, with values often reused
    // so that finds hit and duplicates appear.
    function automatic in_item_t pick_request(mix_t mix);
        in_item_t req;
        int       roll;
        int       ins_cut;
        int       del_cut;
        int       len;
        len     = int'(list_len);
        ins_cut = (mix == MIX_GROW) ? 65 : (mix == MIX_SHRINK) ? 20 : 33;
        del_cut = ins_cut + ((mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 40 : 18);
        roll    = $urandom_range(0, 99);
        if (roll < 3)
            req.opcode = OP_W'($urandom_range(OP_REVERSE + 1, OP_TOP_CODE));
        else if (roll < ins_cut)
            req.opcode = OP_INSERT;
        else if (roll < del_cut)
            req.opcode = OP_DELETE;
        else if (roll < del_cut + (100 - del_cut) / 3)
            req.opcode = OP_GET;
        else if (roll < 93)
            req.opcode = OP_FIND;
        else
            req.opcode = OP_REVERSE;

        if ($urandom_range(0, 9) == 0 || req.opcode > OP_GET)
            req.position = POS_W'($urandom_range(0, POS_MAX));
        else if (req.opcode == OP_INSERT)
            req.position = POS_W'($urandom_range(1, len + 1));
        else
            req.position = POS_W'($urandom_range(1, (len == 0) ? 1 : len));

        roll = $urandom_range(0, 99);
        if (roll < 35 && value_pool.size() != 0)
            req.item_value = value_pool[$urandom_range(0, value_pool.size() - 1)];
        else if (roll < 45)
            req.item_value = corner_values[$urandom_range(0, 3)];
        else
            req.item_value = $urandom;

        if (req.opcode == OP_INSERT) begin
            value_pool.push_back(req.item_value);
            if (value_pool.size() > POOL_DEPTH)
                void'(value_pool.pop_front());
        end
        return req;
    endfunction

    // Called just after a falling edge; returns at the edge that takes the request.
    task automatic send_request(in_item_t req, int idx);
        int gap;
        gap = (idx % 128 < 24) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin : reset_gen
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin : result_sink
        int taken;
        int gap;
        taken = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            else if (taken % 96 < 20)
                gap = 0;
            else
                gap = $urandom_range(0, 15);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    initial begin : request_source
        in_item_t directed [$];
        in_item_t req;
        int       sent;
        sent     = 0;
        directed = '{
            mk(OP_GET, 1, 0), mk(OP_DELETE, 1, 0), mk(OP_FIND, 0, 0), mk(OP_REVERSE, 0, 0),
            mk(OP_INSERT, 0, 5), mk(OP_INSERT, 2, 6),
            mk(OP_INSERT, 1, 32'h7FFF_FFFF), mk(OP_INSERT, 1, 32'h8000_0000),
            mk(OP_INSERT, 3, 32'hFFFF_FFFF), mk(OP_INSERT, 2, 0),
            mk(OP_REVERSE, POS_MAX, 0), mk(OP_GET, 1, 0), mk(OP_GET, 4, 0),
            mk(OP_GET, 5, 0), mk(OP_GET, POS_MAX, 0),
            mk(OP_FIND, 0, 32'h8000_0000), mk(OP_FIND, 0, 32'h1234_5678),
            mk(OP_DELETE, 0, 0), mk(OP_DELETE, 5, 0), mk(OP_DELETE, 2, 0),
            mk(OP_DELETE, 3, 0), mk(OP_INSERT, POS_MAX, 1),
            mk(OP_W'(OP_REVERSE + 1), POS_MAX, '1), mk(OP_W'(OP_REVERSE + 2), 1, 0),
            mk(OP_TOP_CODE, POS_MAX, 32'h8000_0000)
        };
        @(posedge aresetn);
        foreach (directed[k]) begin
            @(negedge aclk);
            send_request(directed[k], sent);
            sent++;
        end
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            @(negedge aclk);
            req = pick_request(mix_t'((k / MODE_SPAN) % 3));
            send_request(req, sent);
            sent++;
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
design/ole_pkg.sv
design/ole_dpath.sv
design/ole_ctrl.sv
design/ordered_list_engine_core.sv
dv/ole_checker.sv
dv/tb_ordered_list_engine_core.sv
